// ----- src/mso_pkg.sv -----
// ----------------------------------------------------------------------------
// mso_pkg: shared types and constants of the mac set occupancy tracker
// sizes of the cell chain, opcodes, status codes and the search token
// ----------------------------------------------------------------------------
`default_nettype none

package mso_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int MAC_W = 48;
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ADDED   = 3'd0,
		ST_REMOVED = 3'd1,
		ST_PRESENT = 3'd2,
		ST_FULL    = 3'd3,
		ST_ABSENT  = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic             active;
		logic             hit;
		logic [IDX_W-1:0] hit_idx;
		logic [MAC_W-1:0] last_addr;
	} token_t;

	// write port broadcast to all cells
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [MAC_W-1:0] data;
	} cell_wr_t;

endpackage

`default_nettype wire

// ----- src/mso_cell.sv -----
// ----------------------------------------------------------------------------
// mso_cell: one slot of the address set
// holds one address, compares it against the key as the token passes, and
// picks up its address into the token when it is the last held slot
// ----------------------------------------------------------------------------
`default_nettype none

module mso_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [mso_pkg::IDX_W-1:0] idx,
	input  wire logic [mso_pkg::MAC_W-1:0] key,
	input  wire logic [mso_pkg::CNT_W-1:0] count,
	input  wire mso_pkg::token_t          tok_in,
	output mso_pkg::token_t               tok_out,
	input  wire mso_pkg::cell_wr_t        wr
);
	import mso_pkg::*;

	logic [MAC_W-1:0] addr_q;
	logic             active_q;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [MAC_W-1:0] last_addr_q;
	logic             live;
	logic             is_last;
	logic             match;

	assign live    = CNT_W'(idx) < count;
	assign is_last = live && (CNT_W'(idx) == count - CNT_W'(1));
	assign match   = tok_in.active && live && (addr_q == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else begin
			active_q <= tok_in.active;
		end
	end

	always_ff @(posedge clk) begin
		hit_q       <= tok_in.hit | match;
		hit_idx_q   <= match ? idx : tok_in.hit_idx;
		last_addr_q <= is_last ? addr_q : tok_in.last_addr;
		if (wr.en && wr.idx == idx) begin
			addr_q <= wr.data;
		end
	end

	assign tok_out = '{active: active_q, hit: hit_q, hit_idx: hit_idx_q,
		last_addr: last_addr_q};

endmodule

`default_nettype wire

// ----- src/mac_set_occupancy_tracker.sv -----
// ----------------------------------------------------------------------------
// mac_set_occupancy_tracker: set of distinct mac addresses with a held count
// add, remove (last entry moves into the freed slot) and clear, one result
// per item with status, slot, new count and empty/non-empty edge flags
// ----------------------------------------------------------------------------
// add and remove: the search token enters the chain once the key is stored and
//   walks the cell chain one cell a cycle; the result is registered from FIN
// clear and the unused opcode skip the search; FIN waits for a free output register
// throughput: one item at a time; the next input is taken once the result
//   sits in the output register, even if it is not yet taken
// reset: arst_n clears the count and all control state; stored addresses stay
// ----------------------------------------------------------------------------
`default_nettype none

module mac_set_occupancy_tracker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // [47:0] mac_addr
	input  wire logic [1:0]  s_tuser,  // [1:0] opcode
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // [7:0] slot, [16:8] entry_count,
	                                   // [17] became_nonempty, [18] became_empty,
	                                   // [23:19] zero
	output logic [2:0]       m_tuser   // [2:0] status
);
	import mso_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		SEARCH,
		FIN
	} state_t;

	state_t           state_q;
	opcode_t          op_q;
	logic [MAC_W-1:0] key_q;
	logic             start_q;
	logic [CNT_W-1:0] count_q;

	// captured search outcome
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [MAC_W-1:0] last_addr_q;

	// output register
	logic             m_tvalid_q;
	logic [2:0]       status_q;
	logic [7:0]       slot_q;
	logic [8:0]       ecount_q;
	logic             nonempty_q;
	logic             empty_q;

	token_t           tok [MAX_ENTRIES+1];
	cell_wr_t         wr;

	logic             in_xfer;
	logic             needs_search;
	logic             out_free;
	logic             finish;

	// result of the item being finished
	status_t          res_status;
	logic [IDX_W-1:0] res_slot;
	logic [CNT_W-1:0] res_count;
	logic             res_nonempty;
	logic             res_empty;

	assign s_tready     = (state_q == IDLE);
	assign in_xfer      = s_tvalid && s_tready;
	assign needs_search = (opcode_t'(s_tuser) == OP_ADD) || (opcode_t'(s_tuser) == OP_REMOVE);
	assign out_free     = !m_tvalid_q || m_tready;
	assign finish       = (state_q == FIN) && out_free;

	// token enters the chain in the cycle after the transfer, once the key is stored
	assign tok[0] = '{active: start_q, hit: 1'b0, hit_idx: '0, last_addr: '0};

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		mso_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(i)),
			.key     (key_q),
			.count   (count_q),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.wr      (wr)
		);
	end

	// decide the outcome and the slot write
	always_comb begin
		res_status   = ST_ABSENT;
		res_slot     = '0;
		res_count    = count_q;
		res_nonempty = 1'b0;
		res_empty    = 1'b0;
		wr.en        = 1'b0;
		wr.idx       = IDX_W'(count_q);
		wr.data      = key_q;
		case (op_q)
			OP_ADD: begin
				if (hit_q) begin
					res_status = ST_PRESENT;
				end else if (count_q >= CNT_W'(MAX_ENTRIES)) begin
					res_status = ST_FULL;
				end else begin
					res_status   = ST_ADDED;
					res_slot     = IDX_W'(count_q);
					res_count    = count_q + CNT_W'(1);
					res_nonempty = (count_q == '0);
					wr.en        = finish;
				end
			end
			OP_REMOVE: begin
				if (hit_q) begin
					res_status = ST_REMOVED;
					res_slot   = hit_idx_q;
					res_count  = count_q - CNT_W'(1);
					res_empty  = (count_q == CNT_W'(1));
					// move the last entry into the freed slot
					wr.idx     = hit_idx_q;
					wr.data    = last_addr_q;
					wr.en      = finish && (CNT_W'(hit_idx_q) != count_q - CNT_W'(1));
				end
			end
			OP_CLEAR: begin
				res_status = ST_CLEARED;
				res_count  = '0;
			end
			default: begin
				res_status = ST_ABSENT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			start_q    <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= in_xfer && needs_search;
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_xfer) begin
						if (needs_search) begin
							state_q <= SEARCH;
						end else begin
							state_q <= FIN;
						end
					end
				end
				SEARCH: begin
					if (tok[MAX_ENTRIES].active) begin
						state_q <= FIN;
					end
				end
				FIN: begin
					if (out_free) begin
						count_q <= res_count;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= opcode_t'(s_tuser);
			key_q <= s_tdata[MAC_W-1:0];
			hit_q <= 1'b0;
		end
		if (state_q == SEARCH && tok[MAX_ENTRIES].active) begin
			hit_q       <= tok[MAX_ENTRIES].hit;
			hit_idx_q   <= tok[MAX_ENTRIES].hit_idx;
			last_addr_q <= tok[MAX_ENTRIES].last_addr;
		end
		if (finish) begin
			status_q   <= res_status;
			slot_q     <= 8'(res_slot);
			ecount_q   <= 9'(res_count);
			nonempty_q <= res_nonempty;
			empty_q    <= res_empty;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {5'd0, empty_q, nonempty_q, ecount_q, slot_q};

	// count never goes past the capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("held count above capacity");

	// the token only leaves the chain while a search is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		tok[MAX_ENTRIES].active |-> state_q == SEARCH)
		else $error("search token out of step with control");

	// an accepted add leaves a non-zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		finish && res_status == ST_ADDED |=> count_q != '0)
		else $error("add left the set empty");

	// both edge flags never rise together
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(nonempty_q && empty_q))
		else $error("both occupancy edge flags set");

	// a taken item makes the block busy, so no second item follows straight after it
	assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_tready)
		else $error("input taken while busy");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the mac set occupancy tracker
// drives add, remove, clear and unused-opcode items over the input stream,
// predicts every result with its own model of the address set and checks
// status, slot, count and edge flags of each result transfer in order
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	import mso_pkg::*;

	localparam int RANDOM_ITEMS = 1660;
	localparam int ROUND_LEN    = 60;
	localparam int POOL_SIZE    = 320;
	localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;

	typedef struct packed {
		status_t     status;
		logic [7:0]  slot;
		logic [8:0]  count;
		logic        nonempty;
		logic        empty;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [47:0] mac_addr
	logic [1:0]  s_tuser;   // [1:0] opcode
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [7:0] slot, [16:8] entry_count, [17] became_nonempty,
	                        // [18] became_empty, [23:19] zero
	logic [2:0]  m_tuser;   // [2:0] status

	// shadow copy of the address set, densely packed like the block keeps it
	logic [47:0] shadow_addr [MAX_ENTRIES];
	int          shadow_count;

	outcome_t    pending_results [$];
	int          error_count;
	bit          quiet;     // when set, neither side idles

	mac_set_occupancy_tracker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb: failure");
		$finish;
	end

	// apply one item to the shadow set and return what the block must answer
	function automatic outcome_t apply_op(input opcode_t op, input logic [47:0] mac);
		outcome_t o;
		int       pos;
		int       prev;
		prev = shadow_count;
		pos = -1;
		o = '{status: ST_ABSENT, slot: '0, count: '0, nonempty: 1'b0, empty: 1'b0};
		for (int i = 0; i < shadow_count; i++)
			if (pos < 0 && shadow_addr[i] == mac)
				pos = i;
		case (op)
		OP_ADD: begin
			if (pos >= 0)
				o.status = ST_PRESENT;
			else if (shadow_count >= MAX_ENTRIES)
				o.status = ST_FULL;
			else begin
				shadow_addr[shadow_count] = mac;
				o.slot = 8'(shadow_count);
				shadow_count++;
				o.status = ST_ADDED;
			end
		end
		OP_REMOVE: begin
			if (pos >= 0) begin
				// last entry fills the hole
				shadow_addr[pos] = shadow_addr[shadow_count - 1];
				shadow_count--;
				o.slot = 8'(pos);
				o.status = ST_REMOVED;
			end
		end
		OP_CLEAR: begin
			shadow_count = 0;
			o.status = ST_CLEARED;
		end
		default: ;
		endcase
		o.count = 9'(shadow_count);
		o.nonempty = (op == OP_ADD) && (prev == 0) && (shadow_count > 0);
		o.empty = (op == OP_REMOVE) && (prev > 0) && (shadow_count == 0);
		return o;
	endfunction

	// one input transfer; valid stays high straight into the next item when
	// no gap is drawn
	task automatic send_item(input opcode_t op, input logic [47:0] mac);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= mac;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(apply_op(op, mac));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [47:0] rand_mac();
		return {$urandom(), 16'($urandom())};
	endfunction

	// result side: stall drawn per result, counted only while one is offered
	initial begin
		outcome_t exp_o;
		int       hold;
		m_tready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("result transfer with nothing expected: tuser %0d tdata %h",
						m_tuser, m_tdata);
					error_count++;
				end else begin
					exp_o = pending_results.pop_front();
					if (m_tuser !== exp_o.status) begin
						$error("status: expected %0d, got %0d", exp_o.status, m_tuser);
						error_count++;
					end
					if (m_tdata[7:0] !== exp_o.slot) begin
						$error("slot: expected %0d, got %0d", exp_o.slot, m_tdata[7:0]);
						error_count++;
					end
					if (m_tdata[16:8] !== exp_o.count) begin
						$error("entry_count: expected %0d, got %0d",
							exp_o.count, m_tdata[16:8]);
						error_count++;
					end
					if (m_tdata[17] !== exp_o.nonempty) begin
						$error("became_nonempty: expected %0d, got %0d",
							exp_o.nonempty, m_tdata[17]);
						error_count++;
					end
					if (m_tdata[18] !== exp_o.empty) begin
						$error("became_empty: expected %0d, got %0d",
							exp_o.empty, m_tdata[18]);
						error_count++;
					end
				end
				hold = quiet ? 0 : $urandom_range(0, 17);
			end
			if (hold > 0 && m_tvalid) begin
				m_tready <= 1'b0;
				hold--;
			end else if (hold > 0)
				m_tready <= 1'b0;
			else
				m_tready <= 1'b1;
		end
	end

	// corner cases on a small set: empty, edges, swaps, extremes of the address
	task automatic test_directed();
		logic [47:0] mac_a;
		logic [47:0] mac_b;
		mac_a = 48'h0012_3456_789A;
		mac_b = 48'h8000_0000_0001;
		send_item(OP_REMOVE, 48'h0000_0000_0123);   // remove on empty set
		send_item(OP_NONE, 48'hFFFF_FFFF_FFFF);     // unused opcode, empty set
		send_item(OP_CLEAR, 48'h0);                 // clear of empty set
		send_item(OP_ADD, 48'h0);                   // first entry raises nonempty
		send_item(OP_ADD, 48'h0);                   // duplicate
		send_item(OP_ADD, 48'hFFFF_FFFF_FFFF);
		send_item(OP_ADD, mac_a);
		send_item(OP_ADD, mac_b);
		send_item(OP_REMOVE, 48'hFFFF_FFFF_FFFF);   // middle slot, last moves in
		send_item(OP_REMOVE, mac_b);
		send_item(OP_REMOVE, 48'hFFFF_FFFF_FFFF);   // now absent
		send_item(OP_NONE, 48'h0);                  // unused opcode on a present address
		send_item(OP_CLEAR, mac_a);                 // clear of a non-empty set, no flag
		send_item(OP_ADD, mac_a);
		send_item(OP_REMOVE, mac_a);                // last entry gone, raises empty
		send_item(OP_ADD, mac_b);
		send_item(OP_ADD, mac_a);
		send_item(OP_REMOVE, mac_a);                // remove of the last slot itself
		send_item(OP_REMOVE, mac_b);
		wait_drained();
	endtask

	// fill every slot, then hit the full set from every side
	task automatic test_full_set();
		logic [47:0] fill_set [MAX_ENTRIES];
		logic [47:0] outsider;
		for (int i = 0; i < MAX_ENTRIES; i++)
			fill_set[i] = {1'b0, 31'($urandom()), 8'($urandom()), 8'(i)};
		outsider = {1'b1, 47'(rand_mac())};
		send_item(OP_CLEAR, rand_mac());
		for (int i = 0; i < MAX_ENTRIES; i++)
			send_item(OP_ADD, fill_set[i]);
		send_item(OP_ADD, outsider);                // dropped, set is full
		send_item(OP_ADD, fill_set[100]);           // duplicate wins over full
		send_item(OP_NONE, fill_set[7]);
		send_item(OP_REMOVE, fill_set[0]);          // top entry moves to slot 0
		send_item(OP_ADD, outsider);                // lands in the top slot
		send_item(OP_REMOVE, outsider);
		send_item(OP_REMOVE, outsider);             // absent
		send_item(OP_ADD, outsider);
		send_item(OP_CLEAR, 48'h0);                 // full set cleared, no flag
		// hold the sender until every result is back
		wait_drained();
	endtask

	// rounds of random traffic over an address pool, each round with its own
	// mix of operations and pool size so the count sweeps empty to full
	task automatic test_random();
		logic [47:0] pool [POOL_SIZE];
		int          sent;
		int          add_pct;
		int          clear_pct;
		int          pool_len;
		int          r;
		opcode_t     op;
		logic [47:0] mac;
		for (int i = 0; i < POOL_SIZE; i++)
			pool[i] = rand_mac();
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
			0: add_pct = 85;
			1: add_pct = 50;
			default: add_pct = 25;
			endcase
			clear_pct = ($urandom_range(0, 2) == 0) ? 3 : 0;
			case ($urandom_range(0, 2))
			0: pool_len = 8;
			1: pool_len = 40;
			default: pool_len = POOL_SIZE;
			endcase
			for (int k = 0; k < ROUND_LEN; k++) begin
				r = $urandom_range(0, 99);
				if (r < clear_pct)
					op = OP_CLEAR;
				else if (r < clear_pct + 2)
					op = OP_NONE;
				else if ($urandom_range(0, 99) < add_pct)
					op = OP_ADD;
				else
					op = OP_REMOVE;
				if ($urandom_range(0, 9) == 0)
					mac = rand_mac();
				else
					mac = pool[$urandom_range(0, pool_len - 1)];
				send_item(op, mac);
				sent++;
			end
			if ($urandom_range(0, 4) == 0)
				wait_drained();
		end
		quiet = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_ADD;
		shadow_count = 0;
		error_count = 0;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_set();
		test_random();

		// let any stray result show up before judging
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
